// File: rtl/ucb_pkg.sv
// ucb_pkg: shared constants, types and codes for the uniform cubic b-spline evaluator
// no dependencies; compiled first
`timescale 1ns / 1ps

package ucb_pkg;

    // table and field geometry
    localparam int MAX_POINTS  = 64;
    localparam int T_FRAC_BITS = 12;
    localparam int T_W         = 18;
    localparam int K_W         = T_W - T_FRAC_BITS;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int PIU_W       = 7;
    localparam int PIU_RESET   = 4;
    localparam int COORD_W     = 16;

    // four banks so the four neighboring points are read in the same cycle
    localparam int NUM_BANKS   = 4;
    localparam int BANK_W      = 2;
    localparam int BANK_DEPTH  = MAX_POINTS / NUM_BANKS;
    localparam int BANK_AW     = IDX_W - BANK_W;

    // weight arithmetic: basis numerators scaled by 6*S^3, then to q0.30
    localparam int WEIGHT_BITS = 30;
    localparam int U_W         = T_FRAC_BITS;
    localparam int V_W         = T_FRAC_BITS + 1;
    localparam int NUM_W       = 3 * T_FRAC_BITS + 3;
    // divisor 6*S^3/2^30 = 3 * 2^DIV_SHIFT
    localparam int DIV_SHIFT   = 3 * T_FRAC_BITS - WEIGHT_BITS + 1;
    localparam int X_W         = NUM_W - DIV_SHIFT;
    localparam int RECIP_SHIFT = X_W + 1;
    localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << RECIP_SHIFT) / 3 + 1);
    localparam logic [NUM_W:0] ROUND_HALF = (NUM_W + 1)'(3) << (DIV_SHIFT - 1);
    localparam int W_W         = 2 * X_W - RECIP_SHIFT;
    localparam int TERM_W      = W_W + 1 + COORD_W;
    localparam int ACC_W       = TERM_W + 2;

    // pipeline depth, output register included
    localparam int NUM_STAGES  = 9;
    localparam int LAST_W_STG  = 6;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] slot;
        t_point           pt;
    } t_point_wr;

    typedef t_point [NUM_BANKS-1:0]          t_point_set;
    typedef logic   [NUM_BANKS-1:0][W_W-1:0] t_weight_set;
    typedef logic   [NUM_BANKS-1:0]          t_term_mask;
    typedef logic   [NUM_STAGES:1]           t_stage_en;

endpackage

// File: rtl/ucb_if.sv
// ucb_if: valid/ready channels for evaluate/write items, curve results and configuration
// depends on ucb_pkg
`timescale 1ns / 1ps

interface ucb_eval_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [ucb_pkg::IDX_W-1:0]          point_index;
    logic signed [ucb_pkg::COORD_W-1:0] coord_x;
    logic signed [ucb_pkg::COORD_W-1:0] coord_y;
    logic signed [ucb_pkg::COORD_W-1:0] coord_z;
    logic [ucb_pkg::T_W-1:0]            t_position;

    modport source (output valid, action, point_index, coord_x, coord_y, coord_z,
                    t_position, input ready);
    modport sink   (input valid, action, point_index, coord_x, coord_y, coord_z,
                    t_position, output ready);
endinterface

interface ucb_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [ucb_pkg::COORD_W-1:0] curve_x;
    logic signed [ucb_pkg::COORD_W-1:0] curve_y;
    logic signed [ucb_pkg::COORD_W-1:0] curve_z;

    modport source (output valid, curve_x, curve_y, curve_z, input ready);
    modport sink   (input valid, curve_x, curve_y, curve_z, output ready);
endinterface

interface ucb_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ucb_pkg::PIU_W-1:0] points_in_use;

    modport source (output valid, points_in_use, input ready);
    modport sink   (input valid, points_in_use, output ready);
endinterface

// File: rtl/ucb_point_store.sv
// ucb_point_store: control point table in four interleaved banks, four reads per cycle
// depends on ucb_pkg
`timescale 1ns / 1ps

module ucb_point_store (
    input  logic                      i_clk,
    input  ucb_pkg::t_point_wr        i_wr,
    input  logic                      i_rd_en,
    input  logic [ucb_pkg::K_W-1:0]   i_k,
    output ucb_pkg::t_point_set       o_pts
);
    import ucb_pkg::*;

    t_point              r_bank [NUM_BANKS][BANK_DEPTH];
    t_point              r_rd   [NUM_BANKS];
    logic [BANK_W-1:0]   r_base;
    logic [IDX_W:0]      w_idx  [NUM_BANKS];
    logic [BANK_W-1:0]   w_base;

    // index of term j is k-1+j; bank holding term 0 is the base
    always_comb begin
        for (int j = 0; j < NUM_BANKS; j++) begin
            w_idx[j] = (IDX_W + 1)'(i_k) + (IDX_W + 1)'(j) - (IDX_W + 1)'(1);
        end
        w_base = w_idx[0][BANK_W-1:0];
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [BANK_W-1:0]  w_term;
        logic [BANK_AW-1:0] w_addr;

        assign w_term = BANK_W'(b) - w_base;
        assign w_addr = w_idx[w_term][IDX_W-1:BANK_W];

        always_ff @(posedge i_clk) begin
            if (i_wr.en && (i_wr.slot[BANK_W-1:0] == BANK_W'(b))) begin
                r_bank[b][i_wr.slot[IDX_W-1:BANK_W]] <= i_wr.pt;
            end
            if (i_rd_en) begin
                r_rd[b] <= r_bank[b][w_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_base <= w_base;
        end
    end

    // rotate bank order back to term order
    always_comb begin
        for (int j = 0; j < NUM_BANKS; j++) begin
            o_pts[j] = r_rd[r_base + BANK_W'(j)];
        end
    end

endmodule

// File: rtl/ucb_weight_pipe.sv
// ucb_weight_pipe: six-stage pipeline from the fraction of t to four q0.30 basis weights
// depends on ucb_pkg
`timescale 1ns / 1ps

module ucb_weight_pipe (
    input  logic                     i_clk,
    input  ucb_pkg::t_stage_en       i_en,
    input  logic [ucb_pkg::U_W-1:0]  i_u,
    output ucb_pkg::t_weight_set     o_weights
);
    import ucb_pkg::*;

    localparam logic [V_W-1:0]   ONE_V = V_W'(1) << T_FRAC_BITS;
    localparam logic [NUM_W:0]   S_CUBE = (NUM_W + 1)'(1) << (3 * T_FRAC_BITS);

    logic [U_W-1:0]       r_u1;
    logic [U_W-1:0]       r_u2;
    logic [V_W-1:0]       r_v2;
    logic [2*U_W-1:0]     r_usq2;
    logic [2*V_W-1:0]     r_vsq2;
    logic [U_W-1:0]       r_u3;
    logic [2*U_W-1:0]     r_usq3;
    logic [3*U_W-1:0]     r_ucube3;
    logic [3*V_W-1:0]     r_vcube3;
    logic [NUM_W-1:0]     r_num4 [NUM_BANKS];
    logic [X_W-1:0]       r_x5   [NUM_BANKS];
    logic [2*X_W-1:0]     r_p6   [NUM_BANKS];

    logic [V_W-1:0]       w_v1;
    logic [NUM_W:0]       w_num  [NUM_BANKS];
    logic [NUM_W:0]       w_uc;
    logic [NUM_W:0]       w_usq_s;
    logic [NUM_W:0]       w_u_s2;
    logic [NUM_W:0]       w_rnd  [NUM_BANKS];

    assign w_v1 = ONE_V - V_W'(r_u1);

    // basis numerators, each 6*S^3 times the weight
    always_comb begin
        w_uc     = (NUM_W + 1)'(r_ucube3);
        w_usq_s  = (NUM_W + 1)'(r_usq3) << T_FRAC_BITS;
        w_u_s2   = (NUM_W + 1)'(r_u3) << (2 * T_FRAC_BITS);
        w_num[0] = (NUM_W + 1)'(r_vcube3);
        w_num[1] = 3 * w_uc + (S_CUBE << 2) - 6 * w_usq_s;
        w_num[2] = 3 * w_usq_s + 3 * w_u_s2 + S_CUBE - 3 * w_uc;
        w_num[3] = w_uc;
        for (int j = 0; j < NUM_BANKS; j++) begin
            w_rnd[j] = (NUM_W + 1)'(r_num4[j]) + ROUND_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_u1 <= i_u;
        end
        if (i_en[2]) begin
            r_u2   <= r_u1;
            r_v2   <= w_v1;
            r_usq2 <= r_u1 * r_u1;
            r_vsq2 <= w_v1 * w_v1;
        end
        if (i_en[3]) begin
            r_u3     <= r_u2;
            r_usq3   <= r_usq2;
            r_ucube3 <= r_usq2 * r_u2;
            r_vcube3 <= r_vsq2 * r_v2;
        end
        for (int j = 0; j < NUM_BANKS; j++) begin
            if (i_en[4]) begin
                r_num4[j] <= NUM_W'(w_num[j]);
            end
            // round half up, drop the power-of-two part of the divisor
            if (i_en[5]) begin
                r_x5[j] <= X_W'(w_rnd[j] >> DIV_SHIFT);
            end
            // divide by three through the reciprocal
            if (i_en[LAST_W_STG]) begin
                r_p6[j] <= r_x5[j] * RECIP;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_BANKS; j++) begin
            o_weights[j] = r_p6[j][2*X_W-1:RECIP_SHIFT];
        end
    end

endmodule

// File: rtl/ucb_blend.sv
// ucb_blend: weighted sum of four control points, rounding and saturation to q8.8
// depends on ucb_pkg; stages 7 to 9 of the evaluator pipeline
`timescale 1ns / 1ps

module ucb_blend (
    input  logic                  i_clk,
    input  ucb_pkg::t_stage_en    i_en,
    input  ucb_pkg::t_weight_set  i_weights,
    input  ucb_pkg::t_point_set   i_pts,
    input  ucb_pkg::t_term_mask   i_mask,
    output ucb_pkg::t_point       o_curve
);
    import ucb_pkg::*;

    localparam int Q_W = ACC_W - WEIGHT_BITS;
    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(1) <<< (WEIGHT_BITS - 1);
    localparam logic signed [Q_W-1:0]   SAT_HI = Q_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_LO = -SAT_HI - Q_W'(1);

    logic signed [TERM_W-1:0]  r_term7 [NUM_BANKS][3];
    t_term_mask                r_mask7;
    logic signed [ACC_W-1:0]   r_acc8  [3];
    logic signed [COORD_W-1:0] r_out9  [3];

    logic signed [W_W:0]       w_ws    [NUM_BANKS];
    logic signed [COORD_W-1:0] w_crd   [NUM_BANKS][3];
    logic signed [ACC_W-1:0]   w_sum   [3];
    logic signed [Q_W-1:0]     w_q     [3];
    logic signed [COORD_W-1:0] w_sat   [3];

    always_comb begin
        for (int j = 0; j < NUM_BANKS; j++) begin
            w_ws[j]     = $signed({1'b0, i_weights[j]});
            w_crd[j][0] = i_pts[j].x;
            w_crd[j][1] = i_pts[j].y;
            w_crd[j][2] = i_pts[j].z;
        end
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = BIAS;
            for (int j = 0; j < NUM_BANKS; j++) begin
                if (r_mask7[j]) begin
                    w_sum[c] = w_sum[c] + ACC_W'(r_term7[j][c]);
                end
            end
            w_q[c] = r_acc8[c][ACC_W-1:WEIGHT_BITS];
            if (w_q[c] > SAT_HI) begin
                w_sat[c] = COORD_W'(SAT_HI);
            end else if (w_q[c] < SAT_LO) begin
                w_sat[c] = COORD_W'(SAT_LO);
            end else begin
                w_sat[c] = COORD_W'(w_q[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_mask7 <= i_mask;
            for (int j = 0; j < NUM_BANKS; j++) begin
                for (int c = 0; c < 3; c++) begin
                    r_term7[j][c] <= w_ws[j] * w_crd[j][c];
                end
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (i_en[8]) begin
                r_acc8[c] <= w_sum[c];
            end
            if (i_en[NUM_STAGES]) begin
                r_out9[c] <= w_sat[c];
            end
        end
    end

    assign o_curve.x = r_out9[0];
    assign o_curve.y = r_out9[1];
    assign o_curve.z = r_out9[2];

endmodule

// File: rtl/uniform_cubic_bspline_eval.sv
// uniform cubic b-spline evaluator: banked point table, weight pipeline and blend; top level
// an accepted evaluate item moves through stages 1 to 9; the result leaves from the stage 9 register
// throughput: one item per cycle, write or evaluate, while ready; nine register stages, output included
// stalls: each stage holds only while the one after it is full, so bubbles close up
// reset (synchronous, active low): empties the pipeline, points_in_use back to 4; the
// point table is not cleared. depends on ucb_pkg, ucb_if, point store, weight pipe, blend
`timescale 1ns / 1ps

module uniform_cubic_bspline_eval (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ucb_eval_if.sink      i_eval,
    ucb_result_if.source  o_result,
    ucb_cfg_if.sink       i_cfg
);
    import ucb_pkg::*;

    // stage map
    //   1: point banks read, t split into k and u, term mask from points_in_use
    //   2: u^2 and (1-u)^2        3: cubes
    //   4: basis numerators       5: rounding offset, drop power-of-two divisor
    //   6: divide by three via reciprocal multiply
    //   7: weight times coordinate, 12 products
    //   8: masked sum plus rounding bias
    //   9: shift, saturate, output register

    logic [PIU_W-1:0]          r_piu;
    logic [NUM_STAGES:1]       r_valid;
    t_term_mask                r_mask  [1:LAST_W_STG];
    t_point_set                r_pts   [2:LAST_W_STG];

    t_stage_en                 w_en;
    logic                      w_in_acc;
    logic                      w_eval_acc;
    t_point_wr                 w_wr;
    logic [PIU_W-1:0]          w_n;
    logic [PIU_W-1:0]          w_e     [NUM_BANKS];
    t_term_mask                w_mask;
    logic [K_W-1:0]            w_k;
    t_point_set                w_pts1;
    t_weight_set               w_weights;
    t_point                    w_curve;

    // config: always ready; the user must write it only while idle, the block itself does not enforce this
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu <= PIU_W'(PIU_RESET);
        end else if (i_cfg.valid) begin
            r_piu <= i_cfg.points_in_use;
        end
    end

    // a stage may load when it is empty or the stage after it moves
    always_comb begin
        w_en[NUM_STAGES] = !r_valid[NUM_STAGES] || o_result.ready;
        for (int i = NUM_STAGES - 1; i >= 1; i--) begin
            w_en[i] = !r_valid[i] || w_en[i+1];
        end
    end

    assign i_eval.ready = w_en[1];
    assign w_in_acc     = i_eval.valid && w_en[1];
    assign w_eval_acc   = w_in_acc && (i_eval.action == ACT_EVAL);

    // writes go straight to the table; only evaluate items enter the pipeline
    assign w_wr.en   = w_in_acc && (i_eval.action == ACT_WRITE);
    assign w_wr.slot = i_eval.point_index;
    assign w_wr.pt.x = i_eval.coord_x;
    assign w_wr.pt.y = i_eval.coord_y;
    assign w_wr.pt.z = i_eval.coord_z;

    assign w_k = i_eval.t_position[T_W-1:T_FRAC_BITS];

    // term j covers point k-1+j; with e = k+j it is in the table when 1 <= e <= n
    always_comb begin
        w_n = (r_piu > PIU_W'(MAX_POINTS)) ? PIU_W'(MAX_POINTS) : r_piu;
        for (int j = 0; j < NUM_BANKS; j++) begin
            w_e[j]    = PIU_W'(w_k) + PIU_W'(j);
            w_mask[j] = (w_e[j] != '0) && (w_e[j] <= w_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[1]) begin
                r_valid[1] <= w_eval_acc;
            end
            for (int i = 2; i <= NUM_STAGES; i++) begin
                if (w_en[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
        end
    end

    // side band: term mask and fetched points ride along with the weight pipeline
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_mask[1] <= w_mask;
        end
        if (w_en[2]) begin
            r_mask[2] <= r_mask[1];
            r_pts[2]  <= w_pts1;
        end
        for (int i = 3; i <= LAST_W_STG; i++) begin
            if (w_en[i]) begin
                r_mask[i] <= r_mask[i-1];
                r_pts[i]  <= r_pts[i-1];
            end
        end
    end

    ucb_point_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd_en (w_en[1]),
        .i_k     (w_k),
        .o_pts   (w_pts1)
    );

    ucb_weight_pipe u_weights (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_u       (i_eval.t_position[T_FRAC_BITS-1:0]),
        .o_weights (w_weights)
    );

    ucb_blend u_blend (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_weights (w_weights),
        .i_pts     (r_pts[LAST_W_STG]),
        .i_mask    (r_mask[LAST_W_STG]),
        .o_curve   (w_curve)
    );

    assign o_result.valid   = r_valid[NUM_STAGES];
    assign o_result.curve_x = w_curve.x;
    assign o_result.curve_y = w_curve.y;
    assign o_result.curve_z = w_curve.z;

endmodule

// File: rtl/ucb_checker.sv
// ucb_checker: port-level assertions for the evaluator, attached by bind
// depends on ucb_pkg and uniform_cubic_bspline_eval
`timescale 1ns / 1ps

module ucb_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_in_action,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input ucb_pkg::t_point i_out_pt
);
    import ucb_pkg::*;

    localparam int CNT_W = $clog2(NUM_STAGES + 1);

    logic [CNT_W-1:0] r_pending;
    logic             w_eval_acc;
    logic             w_out_acc;

    assign w_eval_acc = i_in_valid && i_in_ready && (i_in_action == ACT_EVAL);
    assign w_out_acc  = i_out_valid && i_out_ready;

    // evaluate items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_eval_acc && !w_out_acc) begin
            r_pending <= r_pending + CNT_W'(1);
        end else if (!w_eval_acc && w_out_acc) begin
            r_pending <= r_pending - CNT_W'(1);
        end
    end

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != '0))
        else $error("result without an outstanding evaluate item");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CNT_W'(NUM_STAGES))
        else $error("more items in flight than pipeline stages");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pt))
        else $error("stalled result dropped or changed");

endmodule

bind uniform_cubic_bspline_eval ucb_checker u_ucb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_eval.valid),
    .i_in_ready  (i_eval.ready),
    .i_in_action (i_eval.action),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_pt    ({o_result.curve_x, o_result.curve_y, o_result.curve_z})
);
